// ===== rtl/core/plke_pkg.sv =====
// package for the parameter list key extractor
// holds the transaction structs, parse phase enum and register indexes; no dependencies
package plke_pkg;

    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SENTINEL_ID = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GUID_ID     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_HASH_ID = 2'd2;

    localparam logic [15:0] SENTINEL_ID_RST = 16'd1;
    localparam logic [15:0] GUID_ID_RST     = 16'd80;
    localparam logic [15:0] KEY_HASH_ID_RST = 16'd112;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_SKIP,
        PH_KEY,
        PH_DONE
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       big_endian;
        logic       payload_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] key_byte;
        logic       key_found;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic [15:0] sentinel_id;
        logic [15:0] guid_id;
        logic [15:0] key_hash_id;
    } t_cfg;

endpackage

// ===== rtl/core/plke_parser.sv =====
// per-byte parse state of the parameter list key extractor
// depends on plke_pkg; updates state on each accepted byte and gives at most one result
module plke_parser #(
    parameter int unsigned KEY_BYTES = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_acc,
    input  plke_pkg::t_in_item   i_in,
    input  plke_pkg::t_cfg       i_cfg,
    output logic                 o_res_valid,
    output plke_pkg::t_out_item  o_res
);
    import plke_pkg::*;

    localparam int unsigned KCW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
    localparam logic [KCW:0] KEY_LAST = (KCW+1)'(KEY_BYTES - 1);

    t_phase        r_phase, n_phase;
    logic [1:0]    r_hdr_cnt, n_hdr_cnt;
    logic [15:0]   r_entry_id, n_entry_id;
    logic [15:0]   r_skip, n_skip;
    logic [KCW-1:0] r_key_cnt, n_key_cnt;

    logic [15:0] joined;
    logic [15:0] skip_dec;

    // second byte decides the byte order of both
    assign joined   = i_in.big_endian ? {r_skip[7:0], i_in.data_byte}
                                      : {i_in.data_byte, r_skip[7:0]};
    assign skip_dec = r_skip - 16'd1;

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_entry_id  = r_entry_id;
        n_skip      = r_skip;
        n_key_cnt   = r_key_cnt;
        o_res_valid = 1'b0;
        o_res       = '{key_byte: 8'd0, key_found: 1'b0, last_result: 1'b1};

        case (r_phase)
            PH_HEADER: begin
                case (r_hdr_cnt)
                    2'd0: begin
                        n_entry_id = {8'd0, i_in.data_byte};
                        n_hdr_cnt  = 2'd1;
                    end
                    2'd1: begin
                        n_entry_id = i_in.big_endian ? {r_entry_id[7:0], i_in.data_byte}
                                                     : {i_in.data_byte, r_entry_id[7:0]};
                        n_hdr_cnt  = 2'd2;
                    end
                    2'd2: begin
                        n_skip    = {8'd0, i_in.data_byte};
                        n_hdr_cnt = 2'd3;
                    end
                    default: begin
                        n_hdr_cnt = 2'd0;
                        if (r_entry_id == i_cfg.sentinel_id) begin
                            n_phase     = PH_DONE;
                            o_res_valid = 1'b1;
                        end else if (r_entry_id == i_cfg.guid_id ||
                                     r_entry_id == i_cfg.key_hash_id) begin
                            n_phase   = PH_KEY;
                            n_key_cnt = '0;
                            n_skip    = 16'd0;
                        end else if (joined == 16'd0) begin
                            n_skip = 16'd0;
                        end else begin
                            n_phase = PH_SKIP;
                            n_skip  = joined;
                        end
                    end
                endcase
                if (i_in.payload_end) begin
                    o_res_valid = 1'b1;
                end
            end
            PH_SKIP: begin
                n_skip = skip_dec;
                if (skip_dec == 16'd0) begin
                    n_phase = PH_HEADER;
                end
                o_res_valid = i_in.payload_end;
            end
            PH_KEY: begin
                o_res_valid = 1'b1;
                if ({1'b0, r_key_cnt} == KEY_LAST) begin
                    n_phase = PH_DONE;
                    o_res   = '{key_byte: i_in.data_byte, key_found: 1'b1, last_result: 1'b1};
                end else if (!i_in.payload_end) begin
                    n_key_cnt = r_key_cnt + 1'b1;
                    o_res = '{key_byte: i_in.data_byte, key_found: 1'b1, last_result: 1'b0};
                end
            end
            default: begin
            end
        endcase

        if (i_in.payload_end) begin
            n_phase    = PH_HEADER;
            n_hdr_cnt  = 2'd0;
            n_entry_id = 16'd0;
            n_skip     = 16'd0;
            n_key_cnt  = '0;
        end
        if (!i_acc) begin
            o_res_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HEADER;
            r_hdr_cnt  <= 2'd0;
            r_entry_id <= 16'd0;
            r_skip     <= 16'd0;
            r_key_cnt  <= '0;
        end else if (i_acc) begin
            r_phase    <= n_phase;
            r_hdr_cnt  <= n_hdr_cnt;
            r_entry_id <= n_entry_id;
            r_skip     <= n_skip;
            r_key_cnt  <= n_key_cnt;
        end
    end

`ifndef SYNTHESIS
    a_hdr_only_in_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_HEADER |-> r_hdr_cnt == 2'd0)
        else $error("header count left nonzero outside header phase");

    a_found_only_in_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_res.key_found |-> r_phase == PH_KEY)
        else $error("key byte given outside key phase");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_acc && i_in.payload_end |=> r_phase == PH_HEADER && r_hdr_cnt == 2'd0
                                      && r_key_cnt == '0)
        else $error("payload end did not clear parse state");
`endif

endmodule

// ===== rtl/core/parameter_list_key_extractor.sv =====
// top level of the parameter list key extractor
// depends on plke_pkg and plke_parser; holds config registers and the result register with skid
//
// usage:
//   input channel: i_valid / o_stall with i_in, one payload byte per transaction, carrying
//     the byte order flag and an end-of-payload mark on the final byte
//   output channel: o_valid / i_stall with o_out, zero or one result per input byte
//   config channel: i_cfg_valid / o_cfg_ready with i_cfg_index, i_cfg_data; index 0 sentinel
//     id, 1 guid id, 2 key hash id; other indexes are dropped; o_cfg_ready is always high
// output: a result is registered in the result register, or in the skid entry under a stall
// throughput: one byte per cycle while o_stall is low; the parse state updates on each accepted byte
// stall: the result register plus one skid entry absorb a stalled receiver; o_stall rises
//   only once the skid entry holds a result, so a byte is never accepted without room
// reset: i_rst_n synchronous active low; parse state returns to the start of a header,
//   both output entries empty, config registers back to 1, 80 and 112
// config writes are meant for idle periods only
module parameter_list_key_extractor #(
    parameter int unsigned KEY_BYTES = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // byte input
    input  logic                              i_valid,
    output logic                              o_stall,
    input  plke_pkg::t_in_item                i_in,
    // result output
    output logic                              o_valid,
    input  logic                              i_stall,
    output plke_pkg::t_out_item               o_out,
    // config write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [plke_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [15:0]                       i_cfg_data
);
    import plke_pkg::*;

    t_cfg      r_cfg;
    logic      in_acc;
    logic      res_valid;
    t_out_item res;

    // result register and its skid entry
    logic      r_out_valid;
    t_out_item r_out;
    logic      r_skd_valid;
    t_out_item r_skd;
    logic      out_free;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = r_skd_valid;
    assign in_acc      = i_valid && !r_skd_valid;
    assign o_valid     = r_out_valid;
    assign o_out       = r_out;
    // result register empties this cycle or already is empty
    assign out_free    = !r_out_valid || !i_stall;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sentinel_id <= SENTINEL_ID_RST;
            r_cfg.guid_id     <= GUID_ID_RST;
            r_cfg.key_hash_id <= KEY_HASH_ID_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SENTINEL_ID: r_cfg.sentinel_id <= i_cfg_data;
                CFG_GUID_ID:     r_cfg.guid_id     <= i_cfg_data;
                CFG_KEY_HASH_ID: r_cfg.key_hash_id <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    plke_parser #(
        .KEY_BYTES (KEY_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (in_acc),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // valid bits of the output entries
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            // skid entry moves up first; a new result can only come with the skid empty
            r_out_valid <= r_skd_valid || res_valid;
            r_skd_valid <= 1'b0;
        end else if (res_valid) begin
            r_skd_valid <= 1'b1;
        end
    end

    // payload of the output entries
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_valid ? r_skd : res;
        end else if (res_valid) begin
            r_skd <= res;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry full while result register empty");

    a_skid_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall && r_skd_valid |=> r_skd_valid && $stable(r_skd))
        else $error("skid entry lost under stall");

    a_result_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_valid |=> r_out_valid)
        else $error("accepted result did not reach the output");
`endif

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for parameter_list_key_extractor
// depends on plke_pkg and the extractor rtl; a directed table, then random payloads,
// all results checked in order against a behavioral key extraction predictor or a pinned row
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import plke_pkg::*;

    localparam int unsigned KEY_LEN = 16;

    // index 3 decodes to no register, the write must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    // expected results that a directed row pins down by hand; PREDICT leaves it to the predictor
    localparam t_out_item PREDICT   = '0;
    localparam t_out_item NOT_FOUND = '{key_byte: 8'h00, key_found: 1'b0, last_result: 1'b1};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       big_endian;
        logic       payload_end;
        t_out_item  want;
    } t_stim_row;

    localparam int DIRECTED_N = 25;

    // directed payloads, all under the reset ids (sentinel 1, guid 80, key hash 112)
    localparam t_stim_row DIRECTED_ROWS [DIRECTED_N] = '{
        // big endian sentinel entry, then a trailing byte that ends the payload silently
        '{8'h00, 1'b1, 1'b0, PREDICT},
        '{8'h01, 1'b1, 1'b0, PREDICT},
        '{8'h00, 1'b1, 1'b0, PREDICT},
        '{8'h00, 1'b1, 1'b0, NOT_FOUND},
        '{8'h5A, 1'b1, 1'b1, PREDICT},
        // little endian: id 0x1234 skipping one byte, id 0 of zero length,
        // then a key hash entry whose key is cut short by the payload end
        '{8'h34, 1'b0, 1'b0, PREDICT},
        '{8'h12, 1'b0, 1'b0, PREDICT},
        '{8'h01, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'hFF, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'h70, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'h10, 1'b0, 1'b0, PREDICT},
        '{8'h00, 1'b0, 1'b0, PREDICT},
        '{8'hAB, 1'b0, 1'b0, '{key_byte: 8'hAB, key_found: 1'b1, last_result: 1'b0}},
        '{8'hCD, 1'b0, 1'b1, NOT_FOUND},
        // single byte payload: header cut short
        '{8'hFF, 1'b1, 1'b1, NOT_FOUND},
        // guid entry whose header ends on the final byte of the payload
        '{8'h00, 1'b1, 1'b0, PREDICT},
        '{8'h50, 1'b1, 1'b0, PREDICT},
        '{8'h00, 1'b1, 1'b0, PREDICT},
        '{8'h10, 1'b1, 1'b1, NOT_FOUND}
    };

    // dut ports, every input known from time zero
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_stall;
    t_in_item             i_in        = '0;
    logic                 o_valid;
    logic                 i_stall     = 1'b0;
    t_out_item            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [15:0]          i_cfg_data  = '0;

    // hand-typed expectation that travels with the byte currently offered
    t_out_item pinned_out = PREDICT;

    // predictor copy of the id registers and of the parse state
    t_cfg        id_regs    = '{sentinel_id: SENTINEL_ID_RST, guid_id: GUID_ID_RST,
                                key_hash_id: KEY_HASH_ID_RST};
    t_phase      parse_ph   = PH_HEADER;
    logic [1:0]  hdr_taken  = '0;
    logic [15:0] entry_id   = '0;
    logic [15:0] skip_left  = '0;
    int unsigned key_taken  = 0;

    t_out_item   pending_key_results [$];

    int          err_count     = 0;
    int          bytes_sent    = 0;
    int          idle_pct      = 0;   // sender idle chance per cycle
    int          stall_pct     = 0;   // receiver stall chance per cycle
    bit          hold_off_req  = 1'b0;

    parameter_list_key_extractor #(
        .KEY_BYTES(KEY_LEN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in        (i_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // the flag of the second byte decides the order of both bytes
    function automatic logic [15:0] join_pair(input logic [7:0] first, input logic [7:0] second,
                                              input logic be);
        return be ? {first, second} : {second, first};
    endfunction

    // advance the parse state by one payload byte; returns 1 when it gives a result
    function automatic bit extract_key_byte(input t_in_item it, output t_out_item res);
        bit          hit;
        logic [15:0] len;
        hit = 1'b0;
        res = '0;
        case (parse_ph)
            PH_HEADER: begin
                case (hdr_taken)
                    2'd0: begin
                        entry_id  = {8'h00, it.data_byte};
                        hdr_taken = 2'd1;
                    end
                    2'd1: begin
                        entry_id  = join_pair(entry_id[7:0], it.data_byte, it.big_endian);
                        hdr_taken = 2'd2;
                    end
                    2'd2: begin
                        skip_left = {8'h00, it.data_byte};
                        hdr_taken = 2'd3;
                    end
                    default: begin
                        len       = join_pair(skip_left[7:0], it.data_byte, it.big_endian);
                        hdr_taken = 2'd0;
                        // sentinel wins over a key id of the same value
                        if (entry_id == id_regs.sentinel_id) begin
                            parse_ph = PH_DONE;
                            hit      = 1'b1;
                            res      = NOT_FOUND;
                        end else if (entry_id == id_regs.guid_id ||
                                     entry_id == id_regs.key_hash_id) begin
                            parse_ph  = PH_KEY;
                            key_taken = 0;
                            skip_left = '0;
                        end else if (len == 16'd0) begin
                            skip_left = '0;
                        end else begin
                            parse_ph  = PH_SKIP;
                            skip_left = len;
                        end
                    end
                endcase
                if (it.payload_end && !hit) begin
                    hit = 1'b1;
                    res = NOT_FOUND;
                end
            end
            PH_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'd0)
                    parse_ph = PH_HEADER;
                if (it.payload_end) begin
                    hit = 1'b1;
                    res = NOT_FOUND;
                end
            end
            PH_KEY: begin
                hit = 1'b1;
                if (key_taken + 1 >= KEY_LEN) begin
                    parse_ph = PH_DONE;
                    res      = '{key_byte: it.data_byte, key_found: 1'b1, last_result: 1'b1};
                end else if (it.payload_end) begin
                    // key cut short: this byte reports not found instead
                    res = NOT_FOUND;
                end else begin
                    key_taken = key_taken + 1;
                    res       = '{key_byte: it.data_byte, key_found: 1'b1, last_result: 1'b0};
                end
            end
            default: ;
        endcase
        // any payload end puts the parser back at the start, registers untouched
        if (it.payload_end) begin
            parse_ph  = PH_HEADER;
            hdr_taken = '0;
            entry_id  = '0;
            skip_left = '0;
            key_taken = 0;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // scoreboard: one line per mismatch, capped so a broken design stays readable
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (err_count < 100)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // everything is sampled at the rising edge, before any nonblocking update lands
    always @(posedge i_clk) begin : monitor
        t_out_item got_res;
        t_out_item want_res;
        bit        hit;
        if (i_rst_n) begin
            // result transaction against the oldest expectation
            if (o_valid && !i_stall) begin
                if (pending_key_results.size() == 0) begin
                    report_mismatch("result with nothing pending", 16'(o_out), 16'd0);
                end else begin
                    want_res = pending_key_results.pop_front();
                    if (o_out.key_byte !== want_res.key_byte)
                        report_mismatch("key_byte", 16'(o_out.key_byte),
                                        16'(want_res.key_byte));
                    if (o_out.key_found !== want_res.key_found)
                        report_mismatch("key_found", 16'(o_out.key_found),
                                        16'(want_res.key_found));
                    if (o_out.last_result !== want_res.last_result)
                        report_mismatch("last_result", 16'(o_out.last_result),
                                        16'(want_res.last_result));
                end
            end
            // byte transaction: predictor always steps, a pinned row overrides its answer
            if (i_valid && !o_stall) begin
                hit = extract_key_byte(i_in, got_res);
                if (pinned_out.key_found || pinned_out.last_result)
                    pending_key_results.push_back(pinned_out);
                else if (hit)
                    pending_key_results.push_back(got_res);
            end
            // register write
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SENTINEL_ID: id_regs.sentinel_id = i_cfg_data;
                    CFG_GUID_ID:     id_regs.guid_id     = i_cfg_data;
                    CFG_KEY_HASH_ID: id_regs.key_hash_id = i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver: random stall, or a long counted hold-off on request
    // ------------------------------------------------------------------

    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left    = 64;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // sender
    // ------------------------------------------------------------------

    // offer one byte until taken, then idle with the set chance, drawn anew on each idle clock
    task automatic send_byte(input t_in_item it, input t_out_item pinned);
        i_in       <= it;
        pinned_out <= pinned;
        i_valid    <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    // idle the sender until every expected result is in, plus the output latency
    task automatic drain_results();
        i_valid <= 1'b0;
        while (pending_key_results.size() != 0)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_id_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void push_word(ref logic [7:0] q [$], input logic [15:0] w,
                                      input logic be);
        q.push_back(be ? w[15:8] : w[7:0]);
        q.push_back(be ? w[7:0] : w[15:8]);
    endfunction

    // one random payload: mostly well-formed lists, some truncated, some plain noise
    task automatic send_payload(input bit want_key);
        logic [7:0]  raw [$];
        logic        be;
        logic        mixed;
        logic [15:0] id;
        logic [15:0] len;
        int          n_fill;
        int          tail;
        int          cut;
        bit          open;
        t_in_item    it;
        be    = 1'($urandom);
        mixed = 1'b0;
        open  = 1'b1;
        if (!want_key && $urandom_range(99) < 12) begin
            // noise, byte order flag flipping from byte to byte
            mixed = 1'b1;
            open  = 1'b0;
            repeat ($urandom_range(1, 10)) raw.push_back(8'($urandom));
        end
        n_fill = (want_key || !open) ? 0 : $urandom_range(0, 3);
        for (int f = 0; f < n_fill && open; f++) begin
            do id = 16'($urandom);
            while (id == id_regs.sentinel_id || id == id_regs.guid_id ||
                   id == id_regs.key_hash_id);
            len = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
            push_word(raw, id, be);
            push_word(raw, len, be);
            if (len > 16'd6) begin
                // long skip: the payload ends somewhere inside it
                repeat ($urandom_range(0, 5)) raw.push_back(8'($urandom));
                open = 1'b0;
            end else begin
                repeat (len) raw.push_back(8'($urandom));
            end
        end
        if (open) begin
            tail = want_key ? 0 : $urandom_range(99);
            if (tail < 60) begin
                // key entry, length field is not looked at
                id = $urandom_range(1) ? id_regs.guid_id : id_regs.key_hash_id;
                push_word(raw, id, be);
                push_word(raw, ($urandom_range(3) == 0) ? 16'($urandom) : 16'(KEY_LEN), be);
                repeat (KEY_LEN) raw.push_back(8'($urandom));
                repeat ($urandom_range(0, 3)) raw.push_back(8'($urandom));
            end else if (tail < 85) begin
                push_word(raw, id_regs.sentinel_id, be);
                push_word(raw, 16'($urandom), be);
                repeat ($urandom_range(0, 3)) raw.push_back(8'($urandom));
            end
        end
        // cut the payload short anywhere: inside a header, a skip or a key
        if (!want_key && raw.size() > 1 && $urandom_range(99) < 12) begin
            cut = $urandom_range(1, raw.size() - 1);
            while (raw.size() > cut)
                void'(raw.pop_back());
        end
        if (raw.size() == 0)
            raw.push_back(8'($urandom));
        foreach (raw[i]) begin
            it.data_byte   = raw[i];
            it.big_endian  = mixed ? 1'($urandom) : be;
            it.payload_end = (i == raw.size() - 1);
            send_byte(it, PREDICT);
        end
    endtask

    task automatic run_payloads(input int n_bytes);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_bytes)
            send_payload(1'b0);
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        logic [15:0] pick;
        int          n;
        t_in_item    it;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender gaps light, receiver stalls heavy
        idle_pct  = 23;
        stall_pct = 49;
        foreach (DIRECTED_ROWS[r]) begin
            it.data_byte   = DIRECTED_ROWS[r].data_byte;
            it.big_endian  = DIRECTED_ROWS[r].big_endian;
            it.payload_end = DIRECTED_ROWS[r].payload_end;
            send_byte(it, DIRECTED_ROWS[r].want);
        end
        run_payloads(220);

        // extremes, sentinel sharing the key hash id; index 3 must change nothing
        write_id_reg(CFG_SENTINEL_ID, 16'hFFFF);
        write_id_reg(CFG_GUID_ID, 16'h0000);
        write_id_reg(CFG_KEY_HASH_ID, 16'hFFFF);
        write_id_reg(CFG_IDX_UNUSED, 16'($urandom));

        // sender gaps heavy, receiver stalls light
        idle_pct  = 49;
        stall_pct = 23;
        run_payloads(220);

        write_id_reg(CFG_SENTINEL_ID, 16'($urandom));
        write_id_reg(CFG_GUID_ID, 16'($urandom));
        write_id_reg(CFG_KEY_HASH_ID, 16'($urandom));

        // no idling; receiver holds off while key bytes keep coming, so the
        // output entries fill and the input gets stalled
        idle_pct     = 0;
        stall_pct    = 0;
        hold_off_req = 1'b1;
        send_payload(1'b1);
        send_payload(1'b1);
        // sender waits for every result before going on
        drain_results();
        run_payloads(220);

        // zero extremes, sentinel sharing the guid id
        pick = 16'($urandom);
        write_id_reg(CFG_SENTINEL_ID, 16'h0000);
        write_id_reg(CFG_GUID_ID, 16'h0000);
        write_id_reg(CFG_KEY_HASH_ID, pick);
        run_payloads(220);

        // wind down: wait out the pending results, then the output latency
        i_valid <= 1'b0;
        for (n = 0; n < 20000 && pending_key_results.size() != 0; n++)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (pending_key_results.size() != 0)
            report_mismatch("results never arrived", 16'(pending_key_results.size()), 16'd0);

        if (err_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin : watchdog
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
